/* rtl/core/ucdc_pkg.sv */
// ucdc_pkg: types, request codes and descriptor tables for the cdc control responder
// standalone package, used by every file under rtl/core
`default_nettype none

package ucdc_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  request_type;
		logic [7:0]  request;
		logic [15:0] value;
		logic [15:0] max_length;
		logic [6:0]  out_count;
		logic [55:0] out_payload;
	} in_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_ZLP   = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_STALL = 2'd3
	} act_t;

	typedef struct packed {
		act_t        action;
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_word;
		logic [6:0]  out_address;
		logic        out_address_enable;
		logic        out_configured;
		logic [31:0] out_rate;
		logic [7:0]  out_stop;
		logic [7:0]  out_parity;
		logic [7:0]  out_data_bits;
	} out_t;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_ADDR = 2'd1,
		PEND_LINE = 2'd2
	} pend_t;

	typedef enum logic [1:0] {
		SEL_DEV = 2'd0,
		SEL_CFG = 2'd1,
		SEL_STR = 2'd2
	} sel_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECODE = 2'd1,
		ST_LOAD   = 2'd2,
		ST_SEND   = 2'd3
	} state_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

	localparam logic [1:0] EV_SETUP = 2'd0;
	localparam logic [1:0] EV_OUT   = 2'd1;
	localparam logic [1:0] EV_IN    = 2'd2;

	localparam logic [7:0] RT_STD_OUT     = 8'h00;
	localparam logic [7:0] RT_CLASS_IF    = 8'h21;
	localparam logic [7:0] REQ_SET_ADDR   = 8'h05;
	localparam logic [7:0] REQ_GET_DESC   = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIG = 8'h09;
	localparam logic [7:0] REQ_SET_LINE   = 8'h20;
	localparam logic [7:0] REQ_SET_CTRL   = 8'h22;

	localparam logic [7:0] DT_DEVICE    = 8'h01;
	localparam logic [7:0] DT_CONFIG    = 8'h02;
	localparam logic [7:0] DT_STRING    = 8'h03;
	localparam logic [7:0] DT_QUALIFIER = 8'h06;
	localparam logic [7:0] DT_BOS       = 8'h0f;

	localparam logic [6:0] LINE_CODING_LEN = 7'd7;
	localparam logic [6:0] DEV_LEN = 7'd18;
	localparam logic [6:0] CFG_LEN = 7'd75;
	localparam logic [6:0] STR_MAX = 7'd16;

	localparam logic [7:0] DEV_ROM [18] = '{
		8'h12, 8'h01, 8'h10, 8'h02, 8'hef, 8'h02, 8'h01, 8'h40, 8'hdb, 8'hdb,
		8'h78, 8'h56, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01
	};

	localparam logic [7:0] CFG_ROM [75] = '{
		8'h09, 8'h02, 8'h4b, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'hfa,
		8'h08, 8'h0b, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h00, 8'h00,
		8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
		8'h04, 8'h24, 8'h02, 8'h06,
		8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
		8'h05, 8'h24, 8'h01, 8'h03, 8'h01,
		8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hff,
		8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0a, 8'h00, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00
	};

	localparam logic [7:0] STR_ROM [4][16] = '{
		'{8'h04, 8'h03, 8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h10, 8'h03, 8'h54, 8'h00, 8'h65, 8'h00, 8'h73, 8'h00,
		  8'h74, 8'h00, 8'h69, 8'h00, 8'h6e, 8'h00, 8'h67, 8'h00},
		'{8'h0e, 8'h03, 8'h53, 8'h00, 8'h41, 8'h00, 8'h4d, 8'h00,
		  8'h44, 8'h00, 8'h35, 8'h00, 8'h31, 8'h00, 8'h00, 8'h00},
		'{8'h0e, 8'h03, 8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00,
		  8'h34, 8'h00, 8'h35, 8'h00, 8'h36, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [6:0] STR_LEN [4] = '{7'd4, 7'd16, 7'd14, 7'd14};

	function automatic logic [7:0] rom_byte(input sel_t sel, input logic [1:0] sidx,
		input logic [6:0] addr);
		logic [7:0] b;
		b = 8'h00;
		case (sel)
			SEL_DEV: begin
				if (addr < DEV_LEN) b = DEV_ROM[addr[4:0]];
			end
			SEL_CFG: begin
				if (addr < CFG_LEN) b = CFG_ROM[addr];
			end
			SEL_STR: begin
				if (addr < STR_MAX) b = STR_ROM[sidx][addr[3:0]];
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/ucdc_ctrl.sv */
// ucdc_ctrl: sequencer for the cdc control responder, capture, decode, load and send
// depends on ucdc_pkg
`default_nettype none

module ucdc_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           item_valid,
	output logic          item_ready,
	output logic          result_valid,
	input  wire           result_ready,
	output ucdc_pkg::cmd_t cmd,
	input  ucdc_pkg::sts_t sts
);
	import ucdc_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_nxt = ST_DECODE;
			end
			ST_DECODE: state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = ST_SEND;
			ST_SEND: begin
				if (result_ready) state_nxt = sts.last ? ST_IDLE : ST_LOAD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready   = 1'b0;
		result_valid = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ST_DECODE: cmd.decode = 1'b1;
			ST_LOAD:   cmd.load = 1'b1;
			ST_SEND:   result_valid = 1'b1;
			default: begin
				item_ready   = 1'b0;
				result_valid = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/ucdc_dp.sv */
// ucdc_dp: request decode, device state registers and descriptor word builder
// depends on ucdc_pkg
`default_nettype none

module ucdc_dp (
	input  wire            clk,
	input  wire            arst_n,
	input  ucdc_pkg::cmd_t cmd,
	input  ucdc_pkg::in_t  item,
	output ucdc_pkg::sts_t sts,
	output ucdc_pkg::out_t result
);
	import ucdc_pkg::*;

	in_t         item_q;
	pend_t       pend_q;
	logic [6:0]  paddr_q;
	logic [6:0]  bus_q;
	logic        aen_q;
	logic        cfg_q;
	logic [31:0] rate_q;
	logic [7:0]  stop_q;
	logic [7:0]  parity_q;
	logic [7:0]  dbits_q;
	act_t        act_q;
	logic        stream_q;
	sel_t        sel_q;
	logic [1:0]  sidx_q;
	logic [6:0]  n_q;
	logic [6:0]  pos_q;
	out_t        result_q;

	pend_t       pend_nxt;
	logic [6:0]  paddr_nxt;
	logic [6:0]  bus_nxt;
	logic        aen_nxt;
	logic        cfg_nxt;
	logic [31:0] rate_nxt;
	logic [7:0]  stop_nxt;
	logic [7:0]  parity_nxt;
	logic [7:0]  dbits_nxt;
	act_t        dec_act;
	logic        dec_stream;
	sel_t        dec_sel;
	logic [1:0]  dec_sidx;
	logic [6:0]  dec_len;
	logic [6:0]  dec_n;
	logic [7:0]  dtype;
	logic [6:0]  remain;
	logic [3:0]  cnt;
	logic [63:0] word;
	out_t        result_nxt;

	always_comb begin
		pend_nxt   = pend_q;
		paddr_nxt  = paddr_q;
		bus_nxt    = bus_q;
		aen_nxt    = aen_q;
		cfg_nxt    = cfg_q;
		rate_nxt   = rate_q;
		stop_nxt   = stop_q;
		parity_nxt = parity_q;
		dbits_nxt  = dbits_q;
		dec_act    = ACT_NONE;
		dec_stream = 1'b0;
		dec_sel    = SEL_DEV;
		dec_sidx   = 2'd0;
		dec_len    = 7'd0;
		dtype      = item_q.value[15:8];
		case (item_q.req_type)
			EV_SETUP: begin
				if (item_q.request_type == RT_STD_OUT && item_q.request == REQ_SET_CONFIG) begin
					cfg_nxt = 1'b1;
					dec_act = ACT_ZLP;
				end else if (item_q.request_type == RT_CLASS_IF) begin
					if (item_q.request == REQ_SET_LINE) begin
						pend_nxt = PEND_LINE;
					end else if (item_q.request == REQ_SET_CTRL) begin
						dec_act = ACT_ZLP;
					end
				end else if (item_q.request_type[7]) begin
					if (item_q.request_type[6:0] == 7'd0 && item_q.request == REQ_GET_DESC) begin
						if (dtype == DT_DEVICE) begin
							dec_stream = 1'b1;
							dec_sel    = SEL_DEV;
							dec_len    = DEV_LEN;
						end else if (dtype == DT_CONFIG) begin
							dec_stream = 1'b1;
							dec_sel    = SEL_CFG;
							dec_len    = CFG_LEN;
						end else if (dtype == DT_STRING) begin
							dec_stream = 1'b1;
							dec_sel    = SEL_STR;
							dec_sidx   = (item_q.value[7:2] == 6'd0) ? item_q.value[1:0] : 2'd0;
							dec_len    = STR_LEN[dec_sidx];
						end else if (dtype == DT_QUALIFIER || dtype == DT_BOS) begin
							dec_act = ACT_STALL;
						end
					end
				end else if (item_q.request == REQ_SET_ADDR) begin
					paddr_nxt = item_q.value[6:0];
					pend_nxt  = PEND_ADDR;
					dec_act   = ACT_ZLP;
				end
			end
			EV_OUT: begin
				if (pend_q == PEND_LINE) begin
					if (item_q.out_count == LINE_CODING_LEN) begin
						rate_nxt   = item_q.out_payload[31:0];
						stop_nxt   = item_q.out_payload[39:32];
						parity_nxt = item_q.out_payload[47:40];
						dbits_nxt  = item_q.out_payload[55:48];
					end
					pend_nxt = PEND_NONE;
					dec_act  = ACT_ZLP;
				end
			end
			EV_IN: begin
				if (pend_q == PEND_ADDR) begin
					bus_nxt  = paddr_q;
					aen_nxt  = 1'b1;
					pend_nxt = PEND_NONE;
				end
			end
			default: dec_act = ACT_NONE;
		endcase
		dec_n = (item_q.max_length < {9'd0, dec_len}) ? item_q.max_length[6:0] : dec_len;
		if (dec_stream && dec_n == 7'd0) begin
			dec_stream = 1'b0;
			dec_act    = ACT_ZLP;
		end
	end

	always_comb begin
		remain = n_q - pos_q;
		cnt    = (remain > 7'd8) ? 4'd8 : remain[3:0];
		word   = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < cnt) word[8*i +: 8] = rom_byte(sel_q, sidx_q, pos_q + 7'(i));
		end
		result_nxt                    = '0;
		result_nxt.out_address        = bus_q;
		result_nxt.out_address_enable = aen_q;
		result_nxt.out_configured     = cfg_q;
		result_nxt.out_rate           = rate_q;
		result_nxt.out_stop           = stop_q;
		result_nxt.out_parity         = parity_q;
		result_nxt.out_data_bits      = dbits_q;
		if (stream_q) begin
			result_nxt.action     = ACT_DATA;
			result_nxt.data_word  = word;
			result_nxt.byte_count = cnt;
			result_nxt.last_word  = (remain <= 7'd8);
		end else begin
			result_nxt.action    = act_q;
			result_nxt.last_word = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= PEND_NONE;
			paddr_q  <= '0;
			bus_q    <= '0;
			aen_q    <= 1'b0;
			cfg_q    <= 1'b0;
			rate_q   <= '0;
			stop_q   <= '0;
			parity_q <= '0;
			dbits_q  <= '0;
		end else if (cmd.decode) begin
			pend_q   <= pend_nxt;
			paddr_q  <= paddr_nxt;
			bus_q    <= bus_nxt;
			aen_q    <= aen_nxt;
			cfg_q    <= cfg_nxt;
			rate_q   <= rate_nxt;
			stop_q   <= stop_nxt;
			parity_q <= parity_nxt;
			dbits_q  <= dbits_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.decode) begin
			act_q    <= dec_act;
			stream_q <= dec_stream;
			sel_q    <= dec_sel;
			sidx_q   <= dec_sidx;
			n_q      <= dec_n;
			pos_q    <= 7'd0;
		end
		if (cmd.load) begin
			result_q <= result_nxt;
			pos_q    <= pos_q + 7'd8;
		end
	end

	assign result   = result_q;
	assign sts.last = result_q.last_word;

endmodule

`default_nettype wire

/* rtl/core/usb_cdc_control_responder.sv */
// usb_cdc_control_responder: cdc-acm control endpoint responder, top level
// an event beat taken in idle passes through decode and load before result is valid
// further descriptor words are each loaded once the previous beat is accepted
// up to 10 words per event; one event at a time, the next taken after the last beat
// reset clears the sequencer and all device state (address, configuration, line coding)
// depends on ucdc_pkg, ucdc_ctrl, ucdc_dp
`default_nettype none

module usb_cdc_control_responder (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             item_valid,
	output logic            item_ready,
	input  ucdc_pkg::in_t   item,
	output logic            result_valid,
	input  wire             result_ready,
	output ucdc_pkg::out_t  result
);
	import ucdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ucdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	ucdc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.sts    (sts),
		.result (result)
	);

endmodule

`default_nettype wire

/* rtl/core/ucdc_checker.sv */
// ucdc_checker: port-level checks for the cdc control responder, bound to the top level
// depends on ucdc_pkg and usb_cdc_control_responder
`default_nettype none

module ucdc_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            item_valid,
	input wire            item_ready,
	input wire            result_valid,
	input wire            result_ready,
	input ucdc_pkg::out_t result
);
	import ucdc_pkg::*;

	// stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !item_ready)
		else $error("event taken while a result is pending");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready && !result_valid)
		else $error("no decode cycle after event beat");

	a_single_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action != ACT_DATA |->
			result.last_word && result.byte_count == 4'd0 && result.data_word == 64'd0)
		else $error("non-data result not a clean last beat");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == ACT_DATA |->
			result.byte_count != 4'd0 && result.byte_count <= 4'd8 &&
			(result.last_word || result.byte_count == 4'd8))
		else $error("bad descriptor byte count");

endmodule

bind usb_cdc_control_responder ucdc_checker u_ucdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

/* verif/ucdc_reply_checker.sv */
`timescale 1ns / 100ps
// ucdc_reply_checker: watches the event and result channels of the cdc control responder,
// keeps its own copy of the device state and descriptor tables, and checks every result beat
// depends on ucdc_pkg for the payload types, request codes and action codes
`default_nettype none

module ucdc_reply_checker (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             item_valid,
	input  wire             item_ready,
	input  ucdc_pkg::in_t   item,
	input  wire             result_valid,
	input  wire             result_ready,
	input  ucdc_pkg::out_t  result,
	output int              mismatches,
	output int              awaiting,
	output int              beats_checked
);
	import ucdc_pkg::*;

	typedef enum int {SRC_DEVICE, SRC_CONFIG, SRC_STRING} desc_src_t;

	localparam int LINE_CODING_BYTES = 7;

	localparam logic [7:0] DEVICE_DESC [18] = '{
		8'h12, 8'h01, 8'h10, 8'h02, 8'hef, 8'h02, 8'h01, 8'h40, 8'hdb, 8'hdb,
		8'h78, 8'h56, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01
	};

	localparam logic [7:0] CONFIG_DESC [75] = '{
		8'h09, 8'h02, 8'h4b, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'hfa,
		8'h08, 8'h0b, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h00, 8'h00,
		8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
		8'h04, 8'h24, 8'h02, 8'h06,
		8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
		8'h05, 8'h24, 8'h01, 8'h03, 8'h01,
		8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hff,
		8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0a, 8'h00, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00
	};

	// first byte of each string descriptor is its length
	localparam logic [7:0] STRING_DESC [4][16] = '{
		'{8'h04, 8'h03, 8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h10, 8'h03, 8'h54, 8'h00, 8'h65, 8'h00, 8'h73, 8'h00,
		  8'h74, 8'h00, 8'h69, 8'h00, 8'h6e, 8'h00, 8'h67, 8'h00},
		'{8'h0e, 8'h03, 8'h53, 8'h00, 8'h41, 8'h00, 8'h4d, 8'h00,
		  8'h44, 8'h00, 8'h35, 8'h00, 8'h31, 8'h00, 8'h00, 8'h00},
		'{8'h0e, 8'h03, 8'h31, 8'h00, 8'h32, 8'h00, 8'h33, 8'h00,
		  8'h34, 8'h00, 8'h35, 8'h00, 8'h36, 8'h00, 8'h00, 8'h00}
	};

	pend_t       pend;
	logic [6:0]  addr_next;
	logic [6:0]  bus_addr;
	logic        addr_on;
	logic        cfg_on;
	logic [31:0] baud;
	logic [7:0]  stop_code;
	logic [7:0]  parity_code;
	logic [7:0]  dbits_code;

	out_t expected_replies[$];
	int   fail_total = 0;
	int   beat_total = 0;

	function automatic out_t state_beat(act_t act, logic [63:0] word, logic [3:0] cnt,
		logic last);
		out_t r;
		r.action             = act;
		r.data_word          = word;
		r.byte_count         = cnt;
		r.last_word          = last;
		r.out_address        = bus_addr;
		r.out_address_enable = addr_on;
		r.out_configured     = cfg_on;
		r.out_rate           = baud;
		r.out_stop           = stop_code;
		r.out_parity         = parity_code;
		r.out_data_bits      = dbits_code;
		return r;
	endfunction

	function automatic logic [7:0] desc_byte(desc_src_t src, int sidx, int pos);
		case (src)
			SRC_DEVICE: return DEVICE_DESC[pos];
			SRC_CONFIG: return CONFIG_DESC[pos];
			default:    return STRING_DESC[sidx][pos];
		endcase
	endfunction

	task automatic queue_descriptor(desc_src_t src, int sidx, int len, int wlen);
		int          n;
		int          pos;
		int          cnt;
		int          i;
		logic [63:0] w;
		n = (len < wlen) ? len : wlen;
		if (n == 0) begin
			expected_replies.push_back(state_beat(ACT_ZLP, '0, '0, 1'b1));
			return;
		end
		pos = 0;
		while (pos < n) begin
			cnt = n - pos;
			if (cnt > 8) cnt = 8;
			w = '0;
			for (i = 0; i < cnt; i++) w[8*i +: 8] = desc_byte(src, sidx, pos + i);
			pos += cnt;
			expected_replies.push_back(state_beat(ACT_DATA, w, cnt[3:0], pos >= n));
		end
	endtask

	task automatic predict_replies(in_t ev);
		logic [7:0] dtype;
		int         sidx;
		dtype = ev.value[15:8];
		sidx  = (ev.value[7:0] > 8'd3) ? 0 : int'(ev.value[7:0]);
		case (ev.req_type)
			EV_SETUP: begin
				if (ev.request_type == RT_STD_OUT && ev.request == REQ_SET_CONFIG) begin
					cfg_on = 1'b1;
					expected_replies.push_back(state_beat(ACT_ZLP, '0, '0, 1'b1));
				end else if (ev.request_type == RT_CLASS_IF) begin
					if (ev.request == REQ_SET_LINE) begin
						pend = PEND_LINE;
						expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
					end else if (ev.request == REQ_SET_CTRL)
						expected_replies.push_back(state_beat(ACT_ZLP, '0, '0, 1'b1));
					else
						expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
				end else if (ev.request_type[7]) begin
					if (ev.request_type[6:0] != 7'd0 || ev.request != REQ_GET_DESC)
						expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
					else if (dtype == DT_DEVICE)
						queue_descriptor(SRC_DEVICE, 0, $size(DEVICE_DESC),
							int'(ev.max_length));
					else if (dtype == DT_CONFIG)
						queue_descriptor(SRC_CONFIG, 0, $size(CONFIG_DESC),
							int'(ev.max_length));
					else if (dtype == DT_STRING)
						queue_descriptor(SRC_STRING, sidx, int'(STRING_DESC[sidx][0]),
							int'(ev.max_length));
					else if (dtype == DT_QUALIFIER || dtype == DT_BOS)
						expected_replies.push_back(state_beat(ACT_STALL, '0, '0, 1'b1));
					else
						expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
				end else if (ev.request == REQ_SET_ADDR) begin
					addr_next = ev.value[6:0];
					pend = PEND_ADDR;
					expected_replies.push_back(state_beat(ACT_ZLP, '0, '0, 1'b1));
				end else
					expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
			end
			EV_OUT: begin
				if (pend == PEND_LINE) begin
					if (int'(ev.out_count) == LINE_CODING_BYTES)
						{dbits_code, parity_code, stop_code, baud} = ev.out_payload;
					pend = PEND_NONE;
					expected_replies.push_back(state_beat(ACT_ZLP, '0, '0, 1'b1));
				end else
					expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
			end
			default: begin
				if (ev.req_type == EV_IN && pend == PEND_ADDR) begin
					bus_addr = addr_next;
					addr_on = 1'b1;
					pend = PEND_NONE;
				end
				expected_replies.push_back(state_beat(ACT_NONE, '0, '0, 1'b1));
			end
		endcase
	endtask

	task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR t=%0t beat %0d %s: got %h, expected %h", $realtime, beat_total,
			what, got, want);
		fail_total++;
	endtask

	task automatic check_beat(out_t got);
		out_t want;
		beat_total++;
		if (expected_replies.size() == 0) begin
			log_mismatch("result beat with nothing expected", got.data_word, '0);
			return;
		end
		want = expected_replies.pop_front();
		if (got.action !== want.action)
			log_mismatch("action", 64'(got.action), 64'(want.action));
		if (got.data_word !== want.data_word)
			log_mismatch("data_word", got.data_word, want.data_word);
		if (got.byte_count !== want.byte_count)
			log_mismatch("byte_count", 64'(got.byte_count), 64'(want.byte_count));
		if (got.last_word !== want.last_word)
			log_mismatch("last_word", 64'(got.last_word), 64'(want.last_word));
		if (got.out_address !== want.out_address)
			log_mismatch("out_address", 64'(got.out_address), 64'(want.out_address));
		if (got.out_address_enable !== want.out_address_enable)
			log_mismatch("out_address_enable", 64'(got.out_address_enable),
				64'(want.out_address_enable));
		if (got.out_configured !== want.out_configured)
			log_mismatch("out_configured", 64'(got.out_configured),
				64'(want.out_configured));
		if (got.out_rate !== want.out_rate)
			log_mismatch("out_rate", 64'(got.out_rate), 64'(want.out_rate));
		if (got.out_stop !== want.out_stop)
			log_mismatch("out_stop", 64'(got.out_stop), 64'(want.out_stop));
		if (got.out_parity !== want.out_parity)
			log_mismatch("out_parity", 64'(got.out_parity), 64'(want.out_parity));
		if (got.out_data_bits !== want.out_data_bits)
			log_mismatch("out_data_bits", 64'(got.out_data_bits), 64'(want.out_data_bits));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend        = PEND_NONE;
			addr_next   = '0;
			bus_addr    = '0;
			addr_on     = 1'b0;
			cfg_on      = 1'b0;
			baud        = '0;
			stop_code   = '0;
			parity_code = '0;
			dbits_code  = '0;
			expected_replies.delete();
		end else begin
			if (item_valid && item_ready) predict_replies(item);
			if (result_valid && result_ready) check_beat(result);
		end
		mismatches    <= fail_total;
		awaiting      <= expected_replies.size();
		beats_checked <= beat_total;
	end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// testbench: clock, reset and event stimulus for the cdc control responder, plus the verdict
// depends on ucdc_pkg, usb_cdc_control_responder and ucdc_reply_checker
`default_nettype none

module testbench;
	import ucdc_pkg::*;

	localparam logic [1:0] EV_RESERVED  = 2'd3;
	localparam logic [7:0] RT_STD_IN    = 8'h80;
	localparam logic [7:0] RT_IF_IN     = 8'h81;
	localparam logic [7:0] RT_IF_OUT    = 8'h01;
	localparam logic [7:0] RT_EP_OUT    = 8'h02;
	localparam logic [7:0] REQ_BREAK    = 8'h23;
	localparam logic [7:0] DT_INTERFACE = 8'h04;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_EVENTS = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic result_ready = 1'b0;
	in_t  item = '0;
	wire  item_ready;
	wire  result_valid;
	out_t result;

	int mismatches;
	int awaiting;
	int beats_checked;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int events_sent = 0;

	always #6 clk = ~clk;

	usb_cdc_control_responder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	ucdc_reply_checker reply_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.mismatches    (mismatches),
		.awaiting      (awaiting),
		.beats_checked (beats_checked)
	);

	// receiver: random stalls, plus a long hold-off whenever one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_asked) begin
			result_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end else
			result_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic in_t noise_event();
		in_t ev;
		ev.req_type     = 2'($urandom_range(3));
		ev.request_type = 8'($urandom);
		ev.request      = 8'($urandom);
		ev.value        = 16'($urandom);
		ev.max_length   = 16'($urandom);
		ev.out_count    = 7'($urandom_range(64));
		ev.out_payload  = 56'({$urandom, $urandom});
		return ev;
	endfunction

	function automatic in_t setup_event(logic [7:0] rtype, logic [7:0] req, logic [15:0] val,
		logic [15:0] len);
		in_t ev;
		ev = noise_event();
		ev.req_type     = EV_SETUP;
		ev.request_type = rtype;
		ev.request      = req;
		ev.value        = val;
		ev.max_length   = len;
		return ev;
	endfunction

	function automatic in_t stage_event(logic [1:0] kind, logic [6:0] cnt, logic [55:0] data);
		in_t ev;
		ev = noise_event();
		ev.req_type    = kind;
		ev.out_count   = cnt;
		ev.out_payload = data;
		return ev;
	endfunction

	task automatic offer(in_t ev);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= ev;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		events_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	task automatic random_transfer();
		logic [7:0]  dtype;
		logic [7:0]  idx;
		logic [15:0] len;
		logic [7:0]  rtype;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				case ($urandom_range(5))
					0:       dtype = DT_DEVICE;
					1, 2:    dtype = DT_CONFIG;
					3:       dtype = DT_STRING;
					4:       dtype = $urandom_range(1) ? DT_QUALIFIER : DT_BOS;
					default: dtype = 8'($urandom);
				endcase
				idx = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(5));
				len = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(90));
				offer(setup_event(RT_STD_IN, REQ_GET_DESC, {dtype, idx}, len));
				if ($urandom_range(1)) offer(stage_event(EV_OUT, 7'($urandom_range(64)), '0));
			end
			4: begin
				rtype = $urandom_range(1) ? RT_STD_OUT : {1'b0, 7'($urandom)};
				offer(setup_event(rtype, REQ_SET_ADDR, 16'($urandom), 16'($urandom)));
				if ($urandom_range(3) == 0) offer(noise_event());
				offer(stage_event(EV_IN, 7'($urandom_range(64)), 56'({$urandom, $urandom})));
			end
			5, 6: begin
				offer(setup_event(RT_CLASS_IF, REQ_SET_LINE, 16'($urandom), 16'd7));
				if ($urandom_range(7) == 0) offer(noise_event());
				offer(stage_event(EV_OUT, $urandom_range(4) == 0 ? 7'($urandom_range(64)) : 7'd7,
					56'({$urandom, $urandom})));
			end
			7: begin
				if ($urandom_range(1))
					offer(setup_event(RT_STD_OUT, REQ_SET_CONFIG, 16'($urandom),
						16'($urandom)));
				else
					offer(setup_event(RT_CLASS_IF, REQ_SET_CTRL, 16'($urandom),
						16'($urandom)));
			end
			default: offer(noise_event());
		endcase
	endtask

	initial begin
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(stage_event(EV_IN, '0, '0));
		offer(stage_event(EV_OUT, 7'd7, '1));
		offer(stage_event(EV_RESERVED, 7'd64, '1));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'hffff));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0000));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'hffff));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'd9));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_STRING, 8'h00}, 16'd255));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_STRING, 8'h03}, 16'd1));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_STRING, 8'hff}, 16'd64));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_STRING, 8'h01}, 16'd64));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_QUALIFIER, 8'h00}, 16'd10));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_BOS, 8'h00}, 16'd5));
		offer(setup_event(RT_STD_IN, REQ_GET_DESC, {DT_INTERFACE, 8'h00}, 16'd9));
		offer(setup_event(RT_IF_IN, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'd18));
		offer(setup_event(RT_STD_OUT, REQ_SET_CONFIG, 16'h0001, '0));
		offer(setup_event(RT_IF_OUT, REQ_SET_CONFIG, 16'h0001, '0));
		offer(setup_event(RT_STD_OUT, REQ_SET_ADDR, 16'hffff, '0));
		offer(stage_event(EV_IN, '0, '0));
		offer(setup_event(RT_CLASS_IF, REQ_SET_CTRL, 16'h0003, '0));
		offer(setup_event(RT_CLASS_IF, REQ_SET_LINE, '0, 16'd7));
		offer(stage_event(EV_OUT, 7'd7, '1));
		offer(setup_event(RT_CLASS_IF, REQ_SET_LINE, '0, 16'd7));
		offer(stage_event(EV_OUT, 7'd64, '0));
		offer(setup_event(RT_CLASS_IF, REQ_BREAK, '0, '0));
		offer(setup_event(RT_EP_OUT, REQ_SET_ADDR, 16'h0000, '0));
		offer(stage_event(EV_IN, '0, '0));
		drain();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_gap_pct = 0;  stall_pct <= 0;  end
				1: begin send_gap_pct = 47; stall_pct <= 0;  end
				2: begin send_gap_pct = 0;  stall_pct <= 47; end
				default: begin send_gap_pct = 12; stall_pct <= 12; end
			endcase
			// sender keeps offering through a long receiver hold-off
			if (phase == 0 || phase == 3) hold_asked <= hold_asked + 1;
			while (events_sent < 27 + (phase + 1) * PHASE_EVENTS) random_transfer();
			drain();
		end

		repeat (20) @(posedge clk);
		$display("run covered %0d events and %0d result beats", events_sent, beats_checked);
		$display("idle mixes: none, sender gaps, receiver stalls, both; two long hold-offs");
		if (mismatches == 0)
			$display("usb_cdc_control_responder: match");
		else
			$display("usb_cdc_control_responder: mismatch");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("timeout waiting for the responder");
		$display("usb_cdc_control_responder: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
